[src/spi_display_window_writer_macros.svh]
// Assertion macros shared by the serial display window writer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SPI_DISPLAY_WINDOW_WRITER_MACROS_SVH
`define SPI_DISPLAY_WINDOW_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// Plain property checked at every clock edge outside reset.
`define SDW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies consequence in the next.
`define SDW_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define SDW_ASSERT(lbl, clk, rst_n, prop, msg)
`define SDW_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq, msg)
`endif

`endif

[src/sdw_pkg.sv]
// Types and constants for the serial display window writer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sdw_pkg;

    // DCS command codes
    localparam logic [7:0] CMD_COL_WINDOW  = 8'h2A;
    localparam logic [7:0] CMD_ROW_WINDOW  = 8'h2B;
    localparam logic [7:0] CMD_RAM_WRITE   = 8'h2C;
    localparam logic [7:0] CMD_ACCESS_CTRL = 8'h36;
    localparam logic [7:0] CMD_SOFT_RESET  = 8'h01;

    localparam logic [3:0] SDW_BYTE_BITS = 4'd8;

    localparam int SDW_QUEUE_DEPTH = 2;
    localparam int SDW_PTR_W       = $clog2(SDW_QUEUE_DEPTH);
    localparam int SDW_CNT_W       = $clog2(SDW_QUEUE_DEPTH + 1);

    typedef struct packed {
        logic serial_clock;
        logic chip_select_n;
        logic serial_in;
        logic data_not_command;
        logic reset_n;
    } t_sample;

    typedef struct packed {
        logic        pixel_write;
        logic [8:0]  pixel_column;
        logic [7:0]  pixel_row;
        logic [15:0] pixel_value;
        logic        serial_out;
    } t_pixel;

    // What one pin sample turned into
    typedef enum logic [1:0] {
        TK_IDLE  = 2'd0,
        TK_CLEAR = 2'd1,
        TK_CMD   = 2'd2,
        TK_DATA  = 2'd3
    } t_token_kind;

    typedef struct packed {
        t_token_kind kind;
        logic [7:0]  value;
    } t_token;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] last;
    } t_window;

    // Load one byte of a big-endian start/end pair
    function automatic t_window window_load(t_window w, logic [1:0] pos, logic [7:0] b);
        t_window r;
        r = w;
        case (pos)
            2'd0:    r.first[15:8] = b;
            2'd1:    r.first[7:0]  = b;
            2'd2:    r.last[15:8]  = b;
            default: r.last[7:0]   = b;
        endcase
        return r;
    endfunction

endpackage

[src/sdw_stream_if.sv]
// Valid/ready stream interface with a typed payload.
// Used for the sample, token and pixel channels; no dependencies.
`timescale 1ns / 1ps

interface sdw_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/sdw_front.sv]
// Pin sampler: edge detection, byte deserializer and classification of
// each sample into a token. Depends on sdw_pkg and sdw_stream_if.
`timescale 1ns / 1ps
`include "spi_display_window_writer_macros.svh"

module sdw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdw_stream_if.sink    i_sample,
    sdw_stream_if.source  o_token
);
    import sdw_pkg::*;

    logic       r_prev_cs, n_prev_cs;
    logic       r_prev_sck, n_prev_sck;
    logic [7:0] r_shift, n_shift;
    logic [3:0] r_bits, n_bits;
    logic       r_reset_seen, n_reset_seen;
    t_sample    w_s;
    t_token     w_tok;
    logic       w_accept;

    assign w_s            = i_sample.data;
    assign w_accept       = i_sample.valid && o_token.ready;
    assign i_sample.ready = o_token.ready;
    assign o_token.valid  = i_sample.valid;
    assign o_token.data   = w_tok;

    always_comb begin
        n_prev_cs    = w_s.chip_select_n;
        n_prev_sck   = w_s.serial_clock;
        n_shift      = r_shift;
        n_bits       = r_bits;
        n_reset_seen = r_reset_seen;
        w_tok.kind   = TK_IDLE;
        w_tok.value  = 8'h00;
        if (!w_s.reset_n) begin
            // only the first low sample clears the display side
            if (!r_reset_seen) begin
                w_tok.kind = TK_CLEAR;
            end
            n_reset_seen = 1'b1;
        end else begin
            n_reset_seen = 1'b0;
            if (!r_prev_cs && w_s.chip_select_n) begin
                n_bits = 4'd0;
            end
            if (!w_s.chip_select_n && !r_prev_sck && w_s.serial_clock) begin
                n_shift = {r_shift[6:0], w_s.serial_in};
                n_bits  = n_bits + 4'd1;
                if (n_bits == SDW_BYTE_BITS) begin
                    w_tok.kind  = w_s.data_not_command ? TK_DATA : TK_CMD;
                    w_tok.value = n_shift;
                    n_bits      = 4'd0;
                    n_shift     = 8'h00;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cs    <= 1'b1;
            r_prev_sck   <= 1'b0;
            r_shift      <= 8'h00;
            r_bits       <= 4'd0;
            r_reset_seen <= 1'b0;
        end else if (w_accept) begin
            r_prev_cs    <= n_prev_cs;
            r_prev_sck   <= n_prev_sck;
            r_shift      <= n_shift;
            r_bits       <= n_bits;
            r_reset_seen <= n_reset_seen;
        end
    end

    `SDW_ASSERT(a_byte_on_sck_rise, i_clk, i_rst_n, !(o_token.valid && (w_tok.kind == TK_CMD || w_tok.kind == TK_DATA)) || (w_s.serial_clock && !r_prev_sck && !w_s.chip_select_n), "byte token without SCK rising edge")
    `SDW_ASSERT(a_bits_below_byte, i_clk, i_rst_n, r_bits < SDW_BYTE_BITS, "bit count reached a full byte")

endmodule

[src/sdw_fifo.sv]
// Short token queue between the pin front end and the display engine.
// Depends on sdw_pkg and sdw_stream_if.
`timescale 1ns / 1ps
`include "spi_display_window_writer_macros.svh"

module sdw_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdw_stream_if.sink    i_push,
    sdw_stream_if.source  o_pop
);
    import sdw_pkg::*;

    t_token                 r_mem [SDW_QUEUE_DEPTH];
    logic [SDW_PTR_W-1:0]   r_wr_ptr;
    logic [SDW_PTR_W-1:0]   r_rd_ptr;
    logic [SDW_CNT_W-1:0]   r_count;
    logic                   w_push;
    logic                   w_pop;

    assign i_push.ready = (r_count != SDW_CNT_W'(SDW_QUEUE_DEPTH));
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.data   = r_mem[r_rd_ptr];
    assign w_push       = i_push.valid && i_push.ready;
    assign w_pop        = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + SDW_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + SDW_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + SDW_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - SDW_CNT_W'(1);
            end
        end
    end

    `SDW_ASSERT(a_count_in_range, i_clk, i_rst_n, r_count <= SDW_CNT_W'(SDW_QUEUE_DEPTH), "queue count overflow")

endmodule

[src/sdw_back.sv]
// Display engine: command decode, window registers, pixel pairing, cursor
// and the output register. Depends on sdw_pkg and sdw_stream_if.
`timescale 1ns / 1ps
`include "spi_display_window_writer_macros.svh"

module sdw_back #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdw_stream_if.sink    i_token,
    sdw_stream_if.source  o_pixel
);
    import sdw_pkg::*;

    localparam logic [15:0] LP_COL_LAST = 16'(FRAME_WIDTH - 1);
    localparam logic [15:0] LP_ROW_LAST = 16'(FRAME_HEIGHT - 1);
    localparam logic [15:0] LP_WIDTH    = 16'(FRAME_WIDTH);
    localparam logic [15:0] LP_HEIGHT   = 16'(FRAME_HEIGHT);

    logic [7:0]  r_cmd, n_cmd;
    logic [1:0]  r_param_pos, n_param_pos;
    t_window     r_col_win, n_col_win;
    t_window     r_row_win, n_row_win;
    logic [15:0] r_cur_col, n_cur_col;
    logic [15:0] r_cur_row, n_cur_row;
    logic [7:0]  r_held, n_held;
    logic        r_byte_held, n_byte_held;
    logic        r_out_valid;
    t_pixel      r_out_data;
    t_pixel      w_pix;
    t_token      w_tok;
    logic        w_pop;
    logic        w_clear;
    logic [15:0] w_col_inc;
    logic [15:0] w_row_inc;

    assign w_tok         = i_token.data;
    assign i_token.ready = !r_out_valid || o_pixel.ready;
    assign w_pop         = i_token.valid && i_token.ready;
    assign w_col_inc     = r_cur_col + 16'd1;
    assign w_row_inc     = r_cur_row + 16'd1;
    assign o_pixel.valid = r_out_valid;
    assign o_pixel.data  = r_out_data;

    always_comb begin
        n_cmd       = r_cmd;
        n_param_pos = r_param_pos;
        n_col_win   = r_col_win;
        n_row_win   = r_row_win;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_held      = r_held;
        n_byte_held = r_byte_held;
        w_clear     = 1'b0;
        w_pix       = '0;
        if (w_pop) begin
            case (w_tok.kind)
                TK_CLEAR: begin
                    w_clear = 1'b1;
                end
                TK_CMD: begin
                    n_cmd       = w_tok.value;
                    n_byte_held = 1'b0;
                    if (w_tok.value == CMD_RAM_WRITE) begin
                        n_cur_col = r_col_win.first;
                        n_cur_row = r_row_win.first;
                    end else if (w_tok.value == CMD_SOFT_RESET) begin
                        w_clear = 1'b1;
                    end
                end
                TK_DATA: begin
                    case (r_cmd)
                        CMD_COL_WINDOW: begin
                            n_col_win   = window_load(r_col_win, r_param_pos, w_tok.value);
                            n_param_pos = r_param_pos + 2'd1;
                        end
                        CMD_ROW_WINDOW: begin
                            n_row_win   = window_load(r_row_win, r_param_pos, w_tok.value);
                            n_param_pos = r_param_pos + 2'd1;
                        end
                        CMD_ACCESS_CTRL: begin
                            // exchange bit does not change the write stream
                            n_param_pos = 2'd0;
                        end
                        CMD_RAM_WRITE: begin
                            if (!r_byte_held) begin
                                n_held      = w_tok.value;
                                n_byte_held = 1'b1;
                            end else begin
                                n_byte_held = 1'b0;
                                // outside the frame the pixel is dropped, cursor holds
                                if (r_cur_col < LP_WIDTH && r_cur_row < LP_HEIGHT) begin
                                    w_pix.pixel_write  = 1'b1;
                                    w_pix.pixel_column = r_cur_col[8:0];
                                    w_pix.pixel_row    = r_cur_row[7:0];
                                    w_pix.pixel_value  = {r_held, w_tok.value};
                                    if (w_col_inc > r_col_win.last) begin
                                        n_cur_col = r_col_win.first;
                                        n_cur_row = (w_row_inc > r_row_win.last) ?
                                                    r_row_win.first : w_row_inc;
                                    end else begin
                                        n_cur_col = w_col_inc;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_param_pos = 2'd0;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        if (w_clear) begin
            n_param_pos     = 2'd0;
            n_col_win.first = 16'd0;
            n_col_win.last  = LP_COL_LAST;
            n_row_win.first = 16'd0;
            n_row_win.last  = LP_ROW_LAST;
            n_cur_col       = 16'd0;
            n_cur_row       = 16'd0;
            n_held          = 8'h00;
            n_byte_held     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd           <= 8'h00;
            r_param_pos     <= 2'd0;
            r_col_win.first <= 16'd0;
            r_col_win.last  <= LP_COL_LAST;
            r_row_win.first <= 16'd0;
            r_row_win.last  <= LP_ROW_LAST;
            r_cur_col       <= 16'd0;
            r_cur_row       <= 16'd0;
            r_held          <= 8'h00;
            r_byte_held     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_cmd       <= n_cmd;
            r_param_pos <= n_param_pos;
            r_col_win   <= n_col_win;
            r_row_win   <= n_row_win;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_held      <= n_held;
            r_byte_held <= n_byte_held;
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_pixel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_data <= w_pix;
        end
    end

    `SDW_ASSERT_NEXT(a_clear_restores_window, i_clk, i_rst_n, w_pop && w_tok.kind == TK_CLEAR, r_param_pos == 2'd0 && r_col_win.last == LP_COL_LAST && r_row_win.last == LP_ROW_LAST, "clear did not restore the window")
    `SDW_ASSERT_NEXT(a_write_only_on_data, i_clk, i_rst_n, w_pop && w_tok.kind != TK_DATA, !r_out_data.pixel_write, "pixel written for a non-data transaction")

endmodule

[src/spi_display_window_writer.sv]
// Top level of the serial display window writer: front end, token queue and
// display engine. Depends on sdw_pkg, sdw_stream_if, sdw_front, sdw_fifo, sdw_back.
`timescale 1ns / 1ps
//
// i_sample carries one sample of the display pins (SCK, CSB, MOSI, DC, RESX) per
// transaction; o_pixel returns exactly one result per sample, in order. A result
// with pixel_write set is a frame-store write at pixel_column/pixel_row; otherwise
// the payload is all zero. serial_out is always 0.
// A sample accepted by the front end is written into the two-entry queue, and the
// display engine then moves its result from the queue into the output register.
// Throughput: one sample per cycle while i_sample.ready is high; the engine
// retires one queued token per cycle while the output register is free or being
// read, with cursor advance and window wrap done in that cycle.
// When the receiver stalls, the output register holds its result and the queue
// fills; i_sample.ready drops only once both queue entries are occupied, and
// returns the cycle after a result is taken.
// i_rst_n (synchronous, active low) empties the queue and output register and
// puts the pin edge detectors, shifter and display state at their power-up
// values. The RESX pin in the sample stream clears the display side on its
// first low sample, and then ignores serial traffic until it goes high.
//
module spi_display_window_writer #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdw_stream_if.sink    i_sample,
    sdw_stream_if.source  o_pixel
);
    import sdw_pkg::*;

    sdw_stream_if #(.T(t_token)) w_push ();
    sdw_stream_if #(.T(t_token)) w_pop ();

    sdw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .o_token  (w_push)
    );

    sdw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_pop   (w_pop)
    );

    sdw_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_token (w_pop),
        .o_pixel (o_pixel)
    );

endmodule
